// ===== sv/snsu_pkg.sv =====
package snsu_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned SAT_W  = 72;

    // register indexes on the configuration port
    localparam logic [2:0] REG_THRESHOLD_A     = 3'd0;
    localparam logic [2:0] REG_DROP_LEVEL      = 3'd1;
    localparam logic [2:0] REG_RECOVERY_RATE   = 3'd2;
    localparam logic [2:0] REG_DROP_AMOUNT     = 3'd3;
    localparam logic [2:0] REG_RECOVERY_OFFSET = 3'd4;
    localparam logic [2:0] REG_PEAK_LEVEL      = 3'd5;
    localparam logic [2:0] REG_INV_DECAY_M     = 3'd6;
    localparam logic [2:0] REG_INV_DECAY_M1    = 3'd7;

    localparam logic OP_NEURON  = 1'b0;
    localparam logic OP_SYNAPSE = 1'b1;

    typedef struct packed {
        logic signed [31:0] v;
        logic signed [31:0] cur;
        logic signed [31:0] s;
        logic signed [31:0] h;
        logic signed [31:0] r;
        logic signed [31:0] hr;
    } t_state;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] d;
        logic        [30:0] eps;
        logic        [30:0] beta;
        logic signed [31:0] offset;
        logic signed [31:0] peak;
        logic        [24:0] m;
        logic        [24:0] m1;
    } t_cfg;

    typedef struct packed {
        logic               op;
        logic               oor;
        logic               any;
        logic signed [31:0] drive;
        logic signed [31:0] wsum;
    } t_item;

    typedef struct packed {
        logic signed [31:0] potential;
        logic               spiked;
        logic signed [31:0] fr;
        logic signed [31:0] sc;
    } t_result;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] x);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = 72'sd2147483647;
        lo = -72'sd2147483648;
        if (x > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (x < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = x[31:0];
        end
    endfunction

endpackage

// ===== sv/snsu_state_mem.sv =====
module snsu_state_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output snsu_pkg::t_state     o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  snsu_pkg::t_state     i_wr_data,
    output logic                 o_busy
);

    snsu_pkg::t_state r_mem [DEPTH];
    snsu_pkg::t_state r_rd;
    logic [AW-1:0]    r_clr;
    logic             r_busy;

    // zeroing sweep after reset, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;
    assign o_busy    = r_busy;

endmodule

// ===== sv/snsu_pipe.sv =====
module snsu_pipe (
    input  logic              i_clk,
    input  logic              i_en_c,
    input  logic              i_en_d,
    input  snsu_pkg::t_item   i_item,
    input  snsu_pkg::t_state  i_st,
    input  snsu_pkg::t_cfg    i_cfg,
    output snsu_pkg::t_result o_res,
    output snsu_pkg::t_state  o_wr
);

    // ---- stage B -> C: first products
    logic signed [32:0] w_dvj;
    logic signed [32:0] w_dva;
    logic signed [31:0] w_eps;
    logic signed [25:0] w_m;
    logic signed [25:0] w_m1;

    assign w_dvj = 33'(i_st.v) - 33'(i_cfg.offset);
    assign w_dva = 33'(i_st.v) - 33'(i_cfg.a);
    assign w_eps = $signed({1'b0, i_cfg.eps});
    assign w_m   = $signed({1'b0, i_cfg.m});
    assign w_m1  = $signed({1'b0, i_cfg.m1});

    snsu_pkg::t_item    r_c_item;
    snsu_pkg::t_state   r_c_st;
    logic signed [64:0] r_c_peps;
    logic signed [64:0] r_c_pc1;
    logic signed [57:0] r_c_ps;
    logic signed [57:0] r_c_ph;
    logic signed [57:0] r_c_pr;
    logic signed [57:0] r_c_phr;
    logic signed [57:0] r_c_pw;
    logic        [49:0] r_c_pmm;

    always_ff @(posedge i_clk) begin
        if (i_en_c) begin
            r_c_item <= i_item;
            r_c_st   <= i_st;
            r_c_peps <= w_eps * w_dvj;
            r_c_pc1  <= i_st.v * w_dva;
            r_c_ps   <= i_st.s * w_m;
            r_c_ph   <= i_st.h * w_m1;
            r_c_pr   <= i_st.r * w_m;
            r_c_phr  <= i_st.hr * w_m1;
            r_c_pw   <= i_item.wsum * w_m;
            r_c_pmm  <= i_cfg.m * i_cfg.m1;
        end
    end

    // ---- stage C -> D: second products and side sums
    logic signed [31:0] w_t1;
    logic signed [32:0] w_omv;
    logic signed [32:0] w_beta;
    logic signed [33:0] w_pwq;
    logic signed [71:0] w_mmq;
    logic signed [31:0] w_cur_n;
    logic signed [31:0] w_sn;
    logic signed [31:0] w_rn;
    logic signed [31:0] w_hrn;

    assign w_t1   = snsu_pkg::sat32(72'(r_c_pc1 >>> 24));
    assign w_omv  = 33'sd16777216 - 33'(r_c_st.v);
    assign w_beta = (r_c_st.v > i_cfg.d) ? $signed({2'b00, i_cfg.beta}) : 33'sd0;
    assign w_pwq  = 34'(r_c_pw >>> 24);
    // eps*... and filter decays; the rate kick uses strict greater-than
    assign w_mmq  = (r_c_st.v > i_cfg.peak) ? $signed(72'(r_c_pmm >> 24)) : 72'sd0;
    assign w_cur_n = snsu_pkg::sat32(72'(r_c_st.cur) + 72'(r_c_peps >>> 24));
    assign w_sn   = snsu_pkg::sat32(72'(r_c_st.s) - 72'(r_c_ps >>> 24) + 72'(r_c_st.h));
    assign w_rn   = snsu_pkg::sat32(72'(r_c_st.r) - 72'(r_c_pr >>> 24) + 72'(r_c_st.hr));
    assign w_hrn  = snsu_pkg::sat32(72'(r_c_st.hr) - 72'(r_c_phr >>> 24) + w_mmq);

    snsu_pkg::t_item    r_d_item;
    snsu_pkg::t_state   r_d_st;
    logic signed [31:0] r_d_cur;
    logic signed [31:0] r_d_sn;
    logic signed [31:0] r_d_rn;
    logic signed [31:0] r_d_hrn;
    logic signed [34:0] r_d_hpart;
    logic signed [35:0] r_d_part;
    logic signed [64:0] r_d_pc2;
    logic signed [59:0] r_d_pw2;

    always_ff @(posedge i_clk) begin
        if (i_en_d) begin
            r_d_item  <= r_c_item;
            r_d_st    <= r_c_st;
            r_d_cur   <= w_cur_n;
            r_d_sn    <= w_sn;
            r_d_rn    <= w_rn;
            r_d_hrn   <= w_hrn;
            r_d_hpart <= 35'(r_c_st.h) - 35'(r_c_ph >>> 24);
            r_d_part  <= 36'(r_c_st.v) - 36'(w_beta) - 36'(r_c_st.cur)
                         + 36'(r_c_item.drive) + 36'(r_c_st.s);
            r_d_pc2   <= w_t1 * w_omv;
            r_d_pw2   <= w_pwq * w_m1;
        end
    end

    // ---- stage D: final sums and result selection
    logic signed [31:0] w_t2;
    logic signed [31:0] w_vn;
    logic signed [31:0] w_hn;
    logic signed [31:0] w_pot;

    // cubic term clips after its second product too
    assign w_t2 = snsu_pkg::sat32(72'(r_d_pc2 >>> 24));
    assign w_vn = snsu_pkg::sat32(72'(r_d_part) + 72'(w_t2));
    assign w_hn = snsu_pkg::sat32(72'(r_d_hpart)
                  + (r_d_item.any ? 72'(r_d_pw2 >>> 24) : 72'sd0));

    always_comb begin
        o_wr = r_d_st;
        if (r_d_item.op == snsu_pkg::OP_NEURON) begin
            o_wr.v   = w_vn;
            o_wr.cur = r_d_cur;
        end else begin
            o_wr.s  = r_d_sn;
            o_wr.h  = w_hn;
            o_wr.r  = r_d_rn;
            o_wr.hr = r_d_hrn;
        end
    end

    assign w_pot = o_wr.v;

    always_comb begin
        if (r_d_item.oor) begin
            o_res = '0;
        end else begin
            o_res.potential = w_pot;
            o_res.spiked    = (w_pot >= i_cfg.peak);
            o_res.fr        = o_wr.r;
            o_res.sc        = o_wr.s;
        end
    end

endmodule

// ===== sv/spiking_neuron_synapse_update.sv =====
// Neuron bank with per-neuron synaptic and rate filters, Q8.24 throughout.
// A result passes through stages B (state read), C and D to the output register O.
// Throughput: one request a cycle when the output is not stalled; a request for a
// neuron still in flight waits until that neuron's state has been written back.
// Reset: synchronous active low; state memory is zeroed entry by entry after reset,
// during which no request is taken; registers return to defaults.
module spiking_neuron_synapse_update #(
    parameter int NEURONS = 2048
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [10:0] neuron, [42:11] external_drive, [74:43] weight_sum, [75] any_spike
    input  logic [79:0]   s_axis_tdata,
    // [0] operation
    input  logic [0:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [31:0] potential, [32] spiked, [64:33] filtered_rate_out,
    // [96:65] synaptic_current_out
    output logic [103:0]  m_axis_tdata,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);

    localparam int AW = $clog2(NEURONS);
    localparam int IW = (AW > 11) ? AW : 11;

    snsu_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.a      <= 32'sd4194304;
            r_cfg.d      <= 32'sd4362076;
            r_cfg.eps    <= 31'd83886;
            r_cfg.beta   <= 31'd301990;
            r_cfg.offset <= 32'sd2516582;
            r_cfg.peak   <= 32'sd3355443;
            r_cfg.m      <= 25'd16611105;
            r_cfg.m1     <= 25'd8603700;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                snsu_pkg::REG_THRESHOLD_A:     r_cfg.a      <= i_cfg_data;
                snsu_pkg::REG_DROP_LEVEL:      r_cfg.d      <= i_cfg_data;
                snsu_pkg::REG_RECOVERY_RATE:   r_cfg.eps    <= i_cfg_data[30:0];
                snsu_pkg::REG_DROP_AMOUNT:     r_cfg.beta   <= i_cfg_data[30:0];
                snsu_pkg::REG_RECOVERY_OFFSET: r_cfg.offset <= i_cfg_data;
                snsu_pkg::REG_PEAK_LEVEL:      r_cfg.peak   <= i_cfg_data;
                snsu_pkg::REG_INV_DECAY_M:     r_cfg.m      <= i_cfg_data[24:0];
                snsu_pkg::REG_INV_DECAY_M1:    r_cfg.m1     <= i_cfg_data[24:0];
                default: ;
            endcase
        end
    end

    // request decode
    logic [10:0]     w_neuron;
    logic [IW-1:0]   w_nx;
    logic [AW-1:0]   w_addr;
    snsu_pkg::t_item w_item;

    assign w_neuron     = s_axis_tdata[10:0];
    assign w_nx         = IW'(w_neuron);
    assign w_addr       = w_nx[AW-1:0];
    assign w_item.op    = s_axis_tuser[0];
    assign w_item.oor   = (17'(w_neuron) >= 17'(NEURONS));
    assign w_item.drive = s_axis_tdata[42:11];
    assign w_item.wsum  = s_axis_tdata[74:43];
    assign w_item.any   = s_axis_tdata[75];

    // valid chain: B (state read), C, D, O (output register)
    logic            r_bv, r_cv, r_dv, r_ov;
    logic [AW-1:0]   r_b_addr, r_c_addr, r_d_addr;
    logic            r_d_oor;
    snsu_pkg::t_item r_b_item;
    logic            w_rdy_b, w_rdy_c, w_rdy_d, w_rdy_o;
    logic            w_hazard, w_busy, w_acc, w_ld_o;
    // oor flag of stage C, tracked here for write-back gating
    logic            r_c_item_oor;

    assign w_rdy_o = !r_ov || m_axis_tready;
    assign w_rdy_d = !r_dv || w_rdy_o;
    assign w_rdy_c = !r_cv || w_rdy_d;
    assign w_rdy_b = !r_bv || w_rdy_c;
    assign w_ld_o  = r_dv && w_rdy_o;

    // read-modify-write on the same neuron must not overlap
    assign w_hazard = (r_bv && r_b_addr == w_addr) || (r_cv && r_c_addr == w_addr)
                   || (r_dv && r_d_addr == w_addr);

    assign s_axis_tready = w_rdy_b && !w_busy && !w_hazard;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
            r_cv <= 1'b0;
            r_dv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_rdy_b) r_bv <= w_acc;
            if (w_rdy_c) r_cv <= r_bv;
            if (w_rdy_d) r_dv <= r_cv;
            if (w_rdy_o) r_ov <= r_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_b_addr <= w_addr;
            r_b_item <= w_item;
        end
        if (w_rdy_c) r_c_addr <= r_b_addr;
        if (w_rdy_d) begin
            r_d_addr <= r_c_addr;
            r_d_oor  <= r_c_item_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_c) r_c_item_oor <= r_b_item.oor;
    end

    snsu_pkg::t_state  w_rd, w_wr;
    snsu_pkg::t_result w_res;
    snsu_pkg::t_result r_o_res;

    snsu_state_mem #(
        .DEPTH (NEURONS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_acc),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd),
        .i_wr_en   (w_ld_o && !r_d_oor),
        .i_wr_addr (r_d_addr),
        .i_wr_data (w_wr),
        .o_busy    (w_busy)
    );

    snsu_pipe u_pipe (
        .i_clk  (i_clk),
        .i_en_c (w_rdy_c),
        .i_en_d (w_rdy_d),
        .i_item (r_b_item),
        .i_st   (w_rd),
        .i_cfg  (r_cfg),
        .o_res  (w_res),
        .o_wr   (w_wr)
    );

    always_ff @(posedge i_clk) begin
        if (w_ld_o) r_o_res <= w_res;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_o_res.sc, r_o_res.fr, r_o_res.spiked, r_o_res.potential};

endmodule
